FILE: sv/mfdf_pkg.sv
`default_nettype none

package mfdf_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 16;
    localparam int DEFAULT_ADDRESS_BITS  = 64;

    localparam int SENDER_W    = 64;
    localparam int SEQ_W       = 8;
    localparam int TIME_W      = 16;
    localparam int VERDICT_W   = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TIME_W-1:0] MAX_AGE_RESET = 16'd20;
    localparam logic [SEQ_W-1:0]  INIT_SEQ_RESET = 8'd0;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_AGE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BCAST_FILTER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_SEQ     = 2'd2;

    localparam logic OP_RECEIVE  = 1'b0;
    localparam logic OP_TRANSMIT = 1'b1;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_PASS      = 2'd0,
        VERDICT_DUPLICATE = 2'd1,
        VERDICT_FULL      = 2'd2
    } verdict_t;

    typedef struct packed {
        logic              commit;
        logic              is_broadcast;
        logic              filter_enable;
        logic [SEQ_W-1:0]  frame_sequence;
        logic [TIME_W-1:0] now_seconds;
        logic [TIME_W-1:0] expiry;
    } lookup_req_t;

endpackage

`default_nettype wire

FILE: sv/mfdf_in_if.sv
`default_nettype none

interface mfdf_in_if;

    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [mfdf_pkg::SENDER_W-1:0]       sender_address;
    logic [mfdf_pkg::SEQ_W-1:0]          frame_sequence;
    logic                                is_broadcast;
    logic [mfdf_pkg::TIME_W-1:0]         now_seconds;

    modport source (
        output valid, opcode, sender_address, frame_sequence, is_broadcast, now_seconds,
        input  ready
    );

    modport sink (
        input  valid, opcode, sender_address, frame_sequence, is_broadcast, now_seconds,
        output ready
    );

endinterface

`default_nettype wire

FILE: sv/mfdf_out_if.sv
`default_nettype none

interface mfdf_out_if;

    logic                             valid;
    logic                             ready;
    logic [mfdf_pkg::VERDICT_W-1:0]   verdict;
    logic [mfdf_pkg::SEQ_W-1:0]       transmit_sequence;

    modport source (
        output valid, verdict, transmit_sequence,
        input  ready
    );

    modport sink (
        input  valid, verdict, transmit_sequence,
        output ready
    );

endinterface

`default_nettype wire

FILE: sv/mfdf_table.sv
`default_nettype none

module mfdf_table #(
    parameter int TABLE_ENTRIES = mfdf_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int ADDRESS_BITS  = mfdf_pkg::DEFAULT_ADDRESS_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mfdf_pkg::lookup_req_t         req,
    input  wire logic [ADDRESS_BITS-1:0]       address,
    output mfdf_pkg::verdict_t                 verdict
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [TABLE_ENTRIES-1:0]      valid_reg;
    logic [TABLE_ENTRIES-1:0]      valid_next;
    logic [ADDRESS_BITS-1:0]       addr_reg     [TABLE_ENTRIES];
    logic [mfdf_pkg::SEQ_W-1:0]    uni_seq_reg  [TABLE_ENTRIES];
    logic [mfdf_pkg::TIME_W-1:0]   uni_exp_reg  [TABLE_ENTRIES];
    logic [mfdf_pkg::SEQ_W-1:0]    bc_seq_reg   [TABLE_ENTRIES];
    logic [mfdf_pkg::TIME_W-1:0]   bc_exp_reg   [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0]      hit_vec;
    logic                          any_hit;
    logic                          any_free;
    logic [IDX_W-1:0]              hit_idx;
    logic [IDX_W-1:0]              free_idx;
    logic [mfdf_pkg::SEQ_W-1:0]    last_seq;
    logic [mfdf_pkg::TIME_W-1:0]   last_exp;
    logic [mfdf_pkg::TIME_W-1:0]   age_diff;
    logic                          skip;
    logic                          is_dup;
    logic                          do_alloc;
    logic                          do_update;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            hit_vec[i] = valid_reg[i] && (addr_reg[i] == address);
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        any_hit  = |hit_vec;
        any_free = ~&valid_reg;
    end

    always_comb
    begin
        last_seq = req.is_broadcast ? bc_seq_reg[hit_idx] : uni_seq_reg[hit_idx];
        last_exp = req.is_broadcast ? bc_exp_reg[hit_idx] : uni_exp_reg[hit_idx];
        age_diff = req.now_seconds - last_exp;
        skip     = req.is_broadcast && !req.filter_enable;
        is_dup   = (last_seq == req.frame_sequence) && age_diff[mfdf_pkg::TIME_W-1];

        do_alloc  = 1'b0;
        do_update = 1'b0;
        if (skip)
        begin
            verdict = mfdf_pkg::VERDICT_PASS;
        end
        else if (!any_hit)
        begin
            if (any_free)
            begin
                verdict  = mfdf_pkg::VERDICT_PASS;
                do_alloc = 1'b1;
            end
            else
            begin
                verdict = mfdf_pkg::VERDICT_FULL;
            end
        end
        else if (is_dup)
        begin
            verdict = mfdf_pkg::VERDICT_DUPLICATE;
        end
        else
        begin
            verdict   = mfdf_pkg::VERDICT_PASS;
            do_update = 1'b1;
        end

        valid_next = valid_reg;
        if (req.commit && do_alloc)
        begin
            valid_next[free_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.commit && do_alloc)
        begin
            addr_reg[free_idx]    <= address;
            uni_seq_reg[free_idx] <= req.frame_sequence;
            bc_seq_reg[free_idx]  <= req.frame_sequence;
            uni_exp_reg[free_idx] <= req.expiry;
            bc_exp_reg[free_idx]  <= req.expiry;
        end
        else if (req.commit && do_update)
        begin
            if (req.is_broadcast)
            begin
                bc_seq_reg[hit_idx] <= req.frame_sequence;
                bc_exp_reg[hit_idx] <= req.expiry;
            end
            else
            begin
                uni_seq_reg[hit_idx] <= req.frame_sequence;
                uni_exp_reg[hit_idx] <= req.expiry;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/mac_frame_duplicate_filter.sv
// Channel    Direction  Transfer moves
// request    sink       opcode, sender_address, frame_sequence, is_broadcast, now_seconds
// response   source     verdict, transmit_sequence
// cfg        write      cfg_write_enable, cfg_index, cfg_data
//
// One item is taken per cycle while the response side does not stall; it is captured
// in the input register, then its result goes into the result register for transfer.
// The neighbor table is searched in parallel and updated at the edge the result is stored.
// Reset clears every table valid bit at once and loads the register reset values.
// A stalled response holds the result register, and the request side stalls behind it.
`default_nettype none

module mac_frame_duplicate_filter #(
    parameter int TABLE_ENTRIES = mfdf_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int ADDRESS_BITS  = mfdf_pkg::DEFAULT_ADDRESS_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    mfdf_in_if.sink                                 request,
    mfdf_out_if.source                              response,
    input  wire logic                               cfg_write_enable,
    input  wire logic [mfdf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mfdf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                           in_valid_reg;
    logic                           opcode_reg;
    logic [ADDRESS_BITS-1:0]        address_reg;
    logic [mfdf_pkg::SEQ_W-1:0]     frame_seq_reg;
    logic                           bcast_reg;
    logic [mfdf_pkg::TIME_W-1:0]    now_reg;

    logic                           out_valid_reg;
    logic [mfdf_pkg::VERDICT_W-1:0] verdict_reg;
    logic [mfdf_pkg::SEQ_W-1:0]     tx_seq_reg;

    logic [mfdf_pkg::TIME_W-1:0]    max_age_reg;
    logic                           filter_en_reg;
    logic [mfdf_pkg::SEQ_W-1:0]     counter_reg;
    logic [mfdf_pkg::SEQ_W-1:0]     counter_next;

    logic                           advance;
    logic                           take_in;
    logic                           is_transmit;
    mfdf_pkg::lookup_req_t          lookup;
    mfdf_pkg::verdict_t             table_verdict;

    assign is_transmit      = (opcode_reg == mfdf_pkg::OP_TRANSMIT);
    assign advance          = in_valid_reg && (!out_valid_reg || response.ready);
    assign request.ready    = !in_valid_reg || advance;
    assign take_in          = request.valid && request.ready;

    assign lookup.commit         = advance && !is_transmit;
    assign lookup.is_broadcast   = bcast_reg;
    assign lookup.filter_enable  = filter_en_reg;
    assign lookup.frame_sequence = frame_seq_reg;
    assign lookup.now_seconds    = now_reg;
    assign lookup.expiry         = now_reg + max_age_reg;

    mfdf_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (lookup),
        .address (address_reg),
        .verdict (table_verdict)
    );

    always_comb
    begin
        counter_next = counter_reg;
        if (cfg_write_enable && (cfg_index == mfdf_pkg::CFG_INIT_SEQ))
        begin
            counter_next = cfg_data[mfdf_pkg::SEQ_W-1:0];
        end
        else if (advance && is_transmit)
        begin
            counter_next = counter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_age_reg   <= mfdf_pkg::MAX_AGE_RESET;
            filter_en_reg <= 1'b0;
            counter_reg   <= mfdf_pkg::INIT_SEQ_RESET;
        end
        else
        begin
            counter_reg <= counter_next;
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    mfdf_pkg::CFG_MAX_AGE:      max_age_reg   <= cfg_data;
                    mfdf_pkg::CFG_BCAST_FILTER: filter_en_reg <= cfg_data[0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            opcode_reg    <= request.opcode;
            address_reg   <= request.sender_address[ADDRESS_BITS-1:0];
            frame_seq_reg <= request.frame_sequence;
            bcast_reg     <= request.is_broadcast;
            now_reg       <= request.now_seconds;
        end
        if (advance)
        begin
            if (is_transmit)
            begin
                verdict_reg <= mfdf_pkg::VERDICT_PASS;
                tx_seq_reg  <= counter_reg;
            end
            else
            begin
                verdict_reg <= table_verdict;
                tx_seq_reg  <= '0;
            end
        end
    end

    assign response.valid             = out_valid_reg;
    assign response.verdict           = verdict_reg;
    assign response.transmit_sequence = tx_seq_reg;

endmodule

`default_nettype wire

FILE: sv/mfdf_checker.sv
`default_nettype none

module mfdf_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             req_valid,
    input wire logic                             req_ready,
    input wire logic                             rsp_valid,
    input wire logic                             rsp_ready,
    input wire logic [mfdf_pkg::VERDICT_W-1:0]   rsp_verdict,
    input wire logic [mfdf_pkg::SEQ_W-1:0]       rsp_transmit_sequence
);

    // A transfer on the request side yields a waiting or delivered result after the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |-> ##2 rsp_valid)
    else $error("request transfer produced no result");

    // Only receive results carry a nonzero verdict, and those carry no transmit number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_verdict != mfdf_pkg::VERDICT_PASS)) |-> (rsp_transmit_sequence == '0))
    else $error("nonzero verdict with a transmit number");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_verdict == mfdf_pkg::VERDICT_PASS
                       || rsp_verdict == mfdf_pkg::VERDICT_DUPLICATE
                       || rsp_verdict == mfdf_pkg::VERDICT_FULL))
    else $error("undefined verdict code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_verdict)
                                       && $stable(rsp_transmit_sequence)))
    else $error("stalled result changed");

endmodule

bind mac_frame_duplicate_filter mfdf_checker u_mfdf_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .req_valid             (request.valid),
    .req_ready             (request.ready),
    .rsp_valid             (response.valid),
    .rsp_ready             (response.ready),
    .rsp_verdict           (response.verdict),
    .rsp_transmit_sequence (response.transmit_sequence)
);

`default_nettype wire

FILE: test/mac_frame_duplicate_filter_checker.sv
`default_nettype none

module mac_frame_duplicate_filter_checker
    import mfdf_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    mfdf_in_if                          request,
    mfdf_out_if                         response,
    input  wire logic                   cfg_write_enable,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          mismatches,
    output int                          outstanding,
    output int                          duplicates_seen,
    output int                          full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        verdict_t         verdict;
        logic [SEQ_W-1:0] transmit_sequence;
    } filter_result_t;

    filter_result_t      awaited_results[$];
    filter_result_t      wanted;

    logic                slot_used         [TABLE_ENTRIES];
    logic [SENDER_W-1:0] slot_address      [TABLE_ENTRIES];
    logic [SEQ_W-1:0]    unicast_seq       [TABLE_ENTRIES];
    logic [TIME_W-1:0]   unicast_deadline  [TABLE_ENTRIES];
    logic [SEQ_W-1:0]    broadcast_seq     [TABLE_ENTRIES];
    logic [TIME_W-1:0]   broadcast_deadline[TABLE_ENTRIES];

    logic [TIME_W-1:0]   max_age;
    logic                broadcast_filtering;
    logic [SEQ_W-1:0]    next_transmit;

    function automatic logic still_fresh(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] deadline);
        logic [TIME_W-1:0] gap;
        gap = now - deadline;
        return gap[TIME_W-1];
    endfunction

    function automatic verdict_t screen_frame(input logic [SENDER_W-1:0] address,
                                              input logic [SEQ_W-1:0]    seq,
                                              input logic                bcast,
                                              input logic [TIME_W-1:0]   now);
        logic [TIME_W-1:0] deadline;
        int                hit;
        int                free_slot;
        deadline  = now + max_age;
        hit       = -1;
        free_slot = -1;
        if (bcast && !broadcast_filtering)
            return VERDICT_PASS;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (slot_used[i])
            begin
                if (hit < 0 && slot_address[i] == address)
                    hit = i;
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end
        if (hit < 0)
        begin
            if (free_slot < 0)
                return VERDICT_FULL;
            slot_used[free_slot]          = 1'b1;
            slot_address[free_slot]       = address;
            unicast_seq[free_slot]        = seq;
            broadcast_seq[free_slot]      = seq;
            unicast_deadline[free_slot]   = deadline;
            broadcast_deadline[free_slot] = deadline;
            return VERDICT_PASS;
        end
        if (bcast)
        begin
            if (broadcast_seq[hit] == seq && still_fresh(now, broadcast_deadline[hit]))
                return VERDICT_DUPLICATE;
            broadcast_seq[hit]      = seq;
            broadcast_deadline[hit] = deadline;
        end
        else
        begin
            if (unicast_seq[hit] == seq && still_fresh(now, unicast_deadline[hit]))
                return VERDICT_DUPLICATE;
            unicast_seq[hit]      = seq;
            unicast_deadline[hit] = deadline;
        end
        return VERDICT_PASS;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_results.delete();
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_used[i]          = 1'b0;
                slot_address[i]       = '0;
                unicast_seq[i]        = '0;
                unicast_deadline[i]   = '0;
                broadcast_seq[i]      = '0;
                broadcast_deadline[i] = '0;
            end
            max_age             = MAX_AGE_RESET;
            broadcast_filtering = 1'b0;
            next_transmit       = INIT_SEQ_RESET;
            mismatches          = 0;
            outstanding         = 0;
            duplicates_seen     = 0;
            full_seen           = 0;
        end
        else
        begin
            if (response.valid && response.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: verdict %0d transmit_sequence %0d",
                                 response.verdict, response.transmit_sequence);
                end
                else
                begin
                    wanted = awaited_results.pop_front();
                    if (response.verdict !== wanted.verdict
                        || response.transmit_sequence !== wanted.transmit_sequence)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: verdict expected %0d got %0d, ",
                                      "transmit_sequence expected %0d got %0d"},
                                     wanted.verdict, response.verdict,
                                     wanted.transmit_sequence, response.transmit_sequence);
                    end
                end
            end
            if (request.valid && request.ready)
            begin
                if (request.opcode == OP_TRANSMIT)
                begin
                    wanted.verdict           = VERDICT_PASS;
                    wanted.transmit_sequence = next_transmit;
                    next_transmit            = next_transmit + 1'b1;
                end
                else
                begin
                    wanted.verdict = screen_frame(request.sender_address, request.frame_sequence,
                                                  request.is_broadcast, request.now_seconds);
                    wanted.transmit_sequence = '0;
                    if (wanted.verdict == VERDICT_DUPLICATE)
                        duplicates_seen++;
                    if (wanted.verdict == VERDICT_FULL)
                        full_seen++;
                end
                awaited_results.push_back(wanted);
            end
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    CFG_MAX_AGE:      max_age = cfg_data[TIME_W-1:0];
                    CFG_BCAST_FILTER: broadcast_filtering = cfg_data[0];
                    CFG_INIT_SEQ:     next_transmit = cfg_data[SEQ_W-1:0];
                    default:          ;
                endcase
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: test/mac_frame_duplicate_filter_test.sv
`default_nettype none

module mac_frame_duplicate_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mfdf_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int POOL_SIZE    = DEFAULT_TABLE_ENTRIES;
    localparam int PHASE_ITEMS  = 160;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic                opcode;
        logic [SENDER_W-1:0] sender_address;
        logic [SEQ_W-1:0]    frame_sequence;
        logic                is_broadcast;
        logic [TIME_W-1:0]   now_seconds;
    } frame_request_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                   cfg_write_enable;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mfdf_in_if  request ();
    mfdf_out_if response ();

    int mismatches;
    int outstanding;
    int duplicates_seen;
    int full_seen;

    logic [SENDER_W-1:0] neighbor_pool[POOL_SIZE];
    logic [SEQ_W-1:0]    pool_sequence[POOL_SIZE];
    logic [TIME_W-1:0]   sim_seconds;
    frame_request_t      last_request;
    bit                  quiet;
    bit                  hold_pending;
    int                  requests_sent;
    int                  transmits_sent;
    int                  register_writes;
    int                  settings_used;
    int                  stall_cycles;

    mac_frame_duplicate_filter uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .request          (request),
        .response         (response),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    mac_frame_duplicate_filter_checker verdict_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .request          (request),
        .response         (response),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .duplicates_seen  (duplicates_seen),
        .full_seen        (full_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic frame_request_t receive_item(input logic [SENDER_W-1:0] address,
                                                    input logic [SEQ_W-1:0]    seq,
                                                    input logic                bcast,
                                                    input logic [TIME_W-1:0]   now);
        frame_request_t item;
        item.opcode         = OP_RECEIVE;
        item.sender_address = address;
        item.frame_sequence = seq;
        item.is_broadcast   = bcast;
        item.now_seconds    = now;
        return item;
    endfunction

    function automatic frame_request_t transmit_item();
        frame_request_t item;
        item = receive_item({$urandom, $urandom}, 8'($urandom), 1'($urandom), 16'($urandom));
        item.opcode = OP_TRANSMIT;
        return item;
    endfunction

    task automatic offer(input frame_request_t item);
        request.valid          <= 1'b1;
        request.opcode         <= item.opcode;
        request.sender_address <= item.sender_address;
        request.frame_sequence <= item.frame_sequence;
        request.is_broadcast   <= item.is_broadcast;
        request.now_seconds    <= item.now_seconds;
        do
        begin
            @(posedge clk);
        end
        while (!request.ready);
        requests_sent++;
        if (item.opcode == OP_TRANSMIT)
            transmits_sent++;
        last_request = item;
    endtask

    task automatic rest_sender(input int cycles);
        request.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic settle();
        request.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0]  value);
        cfg_write_enable <= 1'b1;
        cfg_index        <= index;
        cfg_data         <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        @(posedge clk);
        register_writes++;
    endtask

    task automatic configure(input logic [TIME_W-1:0] age, input logic filter,
                             input logic [SEQ_W-1:0] first_sequence);
        settle();
        write_register(CFG_MAX_AGE, age);
        write_register(CFG_BCAST_FILTER, {15'($urandom), filter});
        write_register(CFG_INIT_SEQ, {8'($urandom), first_sequence});
        write_register(CFG_UNUSED, 16'($urandom));
        settings_used++;
    endtask

    task automatic run_phase(input int count, input bit allow_idle);
        frame_request_t item;
        int             slot;
        int             pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                item = transmit_item();
            end
            else if (pick < 40)
            begin
                item = last_request;
                item.opcode = OP_RECEIVE;
            end
            else
            begin
                slot = $urandom_range(0, POOL_SIZE - 1);
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    item.frame_sequence = pool_sequence[slot];
                else if (pick < 8)
                    item.frame_sequence = pool_sequence[slot] + 8'd1;
                else
                    item.frame_sequence = 8'($urandom);
                pool_sequence[slot] = item.frame_sequence;
                item.opcode = OP_RECEIVE;
                if ($urandom_range(0, 9) == 0)
                    item.sender_address = {$urandom, $urandom};
                else
                    item.sender_address = neighbor_pool[slot];
                item.is_broadcast = ($urandom_range(0, 9) < 3);
            end
            if ($urandom_range(0, 19) == 0)
                sim_seconds = sim_seconds + 16'($urandom);
            else if ($urandom_range(0, 9) > 5)
                sim_seconds = sim_seconds + 16'($urandom_range(1, 4));
            item.now_seconds = sim_seconds;
            offer(item);
            if (allow_idle && $urandom_range(0, 5) == 0)
                rest_sender($urandom_range(1, 19));
            if (allow_idle && $urandom_range(0, 199) == 0)
                settle();
        end
    endtask

    initial
    begin : sink_side
        response.ready <= 1'b0;
        forever
        begin
            if (hold_pending)
            begin
                response.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                response.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                response.ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (request.valid && request.ready) || (response.valid && response.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : source_side
        rst_n                  <= 1'b0;
        request.valid          <= 1'b0;
        request.opcode         <= OP_RECEIVE;
        request.sender_address <= '0;
        request.frame_sequence <= '0;
        request.is_broadcast   <= 1'b0;
        request.now_seconds    <= '0;
        cfg_write_enable       <= 1'b0;
        cfg_index              <= CFG_MAX_AGE;
        cfg_data               <= '0;
        stall_cycles           = 0;
        quiet                  = 1'b0;
        hold_pending           = 1'b0;
        sim_seconds            = 16'd300;

        neighbor_pool[0] = '0;
        neighbor_pool[1] = '1;
        neighbor_pool[2] = {4{16'h5555}};
        neighbor_pool[3] = {4{16'hAAAA}};
        for (int i = 4; i < POOL_SIZE; i++)
            neighbor_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < POOL_SIZE; i++)
            pool_sequence[i] = 8'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults after reset: age 20, broadcast filtering off, counter at zero.
        offer(transmit_item());
        offer(receive_item(neighbor_pool[0], 8'd0, 1'b0, 16'd0));
        offer(receive_item(neighbor_pool[0], 8'd0, 1'b0, 16'd19));
        offer(receive_item(neighbor_pool[0], 8'd0, 1'b0, 16'd20));
        offer(receive_item(neighbor_pool[1], 8'd255, 1'b1, 16'hFFFF));
        offer(receive_item(neighbor_pool[1], 8'd255, 1'b0, 16'hFFFF));
        offer(receive_item(neighbor_pool[1], 8'd255, 1'b0, 16'd3));

        configure(16'h8000, 1'b1, 8'hFF);
        offer(transmit_item());
        offer(transmit_item());
        offer(receive_item(neighbor_pool[1], 8'd255, 1'b1, 16'd4));
        offer(receive_item(neighbor_pool[2], 8'hAA, 1'b1, 16'h8000));
        offer(receive_item(neighbor_pool[2], 8'hAA, 1'b1, 16'h8000));

        configure(16'd0, 1'b1, 8'd0);
        offer(receive_item(neighbor_pool[3], 8'd7, 1'b0, 16'd100));
        offer(receive_item(neighbor_pool[3], 8'd7, 1'b0, 16'd100));
        for (int i = 4; i < POOL_SIZE; i++)
            offer(receive_item(neighbor_pool[i], pool_sequence[i], 1'b0, 16'd200));
        offer(receive_item({$urandom, $urandom}, 8'd1, 1'b0, 16'd200));

        configure(16'd20, 1'b1, 8'd0);
        run_phase(PHASE_ITEMS, 1'b1);
        configure(16'd5, 1'b0, 8'h80);
        run_phase(PHASE_ITEMS, 1'b1);

        configure(16'hFFFF, 1'b1, 8'hFF);
        hold_pending = 1'b1;
        run_phase(60, 1'b0);
        run_phase(PHASE_ITEMS - 60, 1'b1);

        configure(16'h8000, 1'b1, 8'($urandom));
        run_phase(PHASE_ITEMS, 1'b1);
        configure(16'd1, 1'b0, 8'($urandom));
        run_phase(PHASE_ITEMS, 1'b1);

        configure(16'($urandom_range(2, 60)), 1'($urandom), 8'($urandom));
        quiet = 1'b1;
        run_phase(PHASE_ITEMS, 1'b0);
        settle();

        $display("Sent %0d requests (%0d transmit) under %0d register settings, %0d writes.",
                 requests_sent, transmits_sent, settings_used, register_writes);
        $display("Predicted %0d duplicates and %0d table-full verdicts; one %0d-cycle stall.",
                 duplicates_seen, full_seen, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
